[rtl/fbs_pkg.sv]
// Shared types, widths and helpers for the fiber bending-force stencil.
`default_nettype none
package fbs_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = 35;
  localparam int unsigned ProdW    = 52;
  localparam int unsigned FW       = 52;
  localparam int unsigned AccW     = 54;
  localparam int unsigned FracBits = 16;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw   = $clog2(FifoDepth);
  localparam int unsigned CntW     = $clog2(FifoDepth + 1);
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);

  localparam logic signed [AccW-1:0] AccMax = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] AccMin = AccW'(-64'sd2147483648);

  typedef logic signed [CoordW-1:0] coord_t;

  // Control carried alongside one point through the lanes
  typedef struct packed {
    logic       vld;
    logic       win;
    logic [1:0] held;
    logic       last;
  } fbs_ctrl_t;

  // Candidate result values of one lane, in point order
  typedef struct packed {
    coord_t slot0;
    coord_t slot1;
    coord_t slot2;
  } fbs_cand_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   fiber_end;
  } fbs_result_t;

  function automatic coord_t sat_coord(input logic signed [AccW-1:0] v);
    coord_t r;
    if (v > AccMax) begin
      r = coord_t'(AccMax);
    end else if (v < AccMin) begin
      r = coord_t'(AccMin);
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/fbs_lane.sv]
// One coordinate lane: position window, scaled second difference, force window.
`default_nettype none
module fbs_lane (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fbs_pkg::fbs_ctrl_t acc_i,
  input  wire fbs_pkg::coord_t   pos_i,
  input  wire fbs_pkg::coord_t   frc_i,
  input  wire logic [31:0]       rigidity_i,
  input  wire fbs_pkg::fbs_ctrl_t upd_i,
  output fbs_pkg::fbs_cand_t     cand_o
);
  import fbs_pkg::*;

  coord_t pw0_q, pw1_q;
  logic signed [DiffW-1:0] diff_d, diff_q;
  coord_t frc1_q, frc2_q, frc3_q;
  logic signed [ProdW-1:0] ph_d, pl_d, ph_q, pl_q;
  logic signed [FW-1:0]    f_d, f_q;
  logic signed [HalfW:0]   rig_hi, rig_lo;
  coord_t pf0_q, pf1_q;
  logic signed [AccW-1:0]  f_ext;
  coord_t sat_a, sat_b, sat_c;

  // Position window, written when the request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw0_q <= '0;
      pw1_q <= '0;
    end else if (acc_i.vld) begin
      if (acc_i.win) begin
        pw0_q <= pw1_q;
        pw1_q <= pos_i;
      end else if (acc_i.held == 2'd0) begin
        pw0_q <= pos_i;
      end else begin
        pw1_q <= pos_i;
      end
    end
  end

  assign diff_d = DiffW'(pw0_q) - (DiffW'(pw1_q) <<< 1) + DiffW'(pos_i);

  assign rig_hi = $signed({1'b0, rigidity_i[31:HalfW]});
  assign rig_lo = $signed({1'b0, rigidity_i[HalfW-1:0]});
  assign ph_d   = ProdW'(diff_q) * ProdW'(rig_hi);
  assign pl_d   = ProdW'(diff_q) * ProdW'(rig_lo);
  assign f_d    = FW'(ph_q) + FW'(pl_q >>> FracBits);

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    frc1_q <= frc_i;
    ph_q   <= ph_d;
    pl_q   <= pl_d;
    frc2_q <= frc1_q;
    f_q    <= f_d;
    frc3_q <= frc2_q;
  end

  assign f_ext = AccW'(f_q);
  assign sat_a = sat_coord(AccW'(pf0_q) - f_ext);
  assign sat_b = sat_coord(AccW'(pf1_q) + (f_ext <<< 1));
  assign sat_c = sat_coord(AccW'(frc3_q) - f_ext);

  // Force window, updated in stream order at the end of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf0_q <= '0;
      pf1_q <= '0;
    end else if (upd_i.vld) begin
      if (upd_i.win) begin
        pf0_q <= sat_b;
        pf1_q <= sat_c;
      end else if (upd_i.held == 2'd0) begin
        pf0_q <= frc3_q;
      end else begin
        pf1_q <= frc3_q;
      end
    end
  end

  always_comb begin
    if (upd_i.win) begin
      cand_o.slot0 = sat_a;
      cand_o.slot1 = sat_b;
    end else begin
      cand_o.slot0 = (upd_i.held == 2'd0) ? frc3_q : pf0_q;
      cand_o.slot1 = frc3_q;
    end
    cand_o.slot2 = sat_c;
  end

endmodule
`default_nettype wire

[rtl/fbs_merge.sv]
// Merging stage: gathers lane candidates into results and queues them.
`default_nettype none
module fbs_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fbs_pkg::fbs_ctrl_t upd_i,
  input  wire fbs_pkg::fbs_cand_t cand_x_i,
  input  wire fbs_pkg::fbs_cand_t cand_y_i,
  input  wire fbs_pkg::fbs_cand_t cand_z_i,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output fbs_pkg::fbs_result_t    result_o
);
  import fbs_pkg::*;

  fbs_result_t mem_q [FifoDepth];
  fbs_result_t wr_res [MaxRes];
  logic [FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [ResCntW-1:0] wr_n;

  // Number of results this point releases
  always_comb begin
    wr_n = '0;
    if (upd_i.vld) begin
      if (upd_i.win) begin
        wr_n = upd_i.last ? ResCntW'(3) : ResCntW'(1);
      end else if (upd_i.last) begin
        wr_n = (upd_i.held == 2'd0) ? ResCntW'(1) : ResCntW'(2);
      end
    end
  end

  always_comb begin
    wr_res[0] = '{x: cand_x_i.slot0, y: cand_y_i.slot0, z: cand_z_i.slot0,
                  fiber_end: upd_i.last && (wr_n == ResCntW'(1))};
    wr_res[1] = '{x: cand_x_i.slot1, y: cand_y_i.slot1, z: cand_z_i.slot1,
                  fiber_end: upd_i.last && (wr_n == ResCntW'(2))};
    wr_res[2] = '{x: cand_x_i.slot2, y: cand_y_i.slot2, z: cand_z_i.slot2,
                  fiber_end: upd_i.last};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (ResCntW'(k) < wr_n) begin
        mem_q[FifoAw'(wr_ptr_q + FifoAw'(k))] <= wr_res[k];
      end
    end
  end

  assign valid_o  = (cnt_q != '0);
  assign result_o = mem_q[rd_ptr_q];
  assign cnt_d    = cnt_q + CntW'(wr_n) - CntW'(pop_i && valid_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoAw'(wr_n);
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/fiber_bending_force_stencil_top.sv]
// Fiber bending-force stencil, top level: lanes per coordinate plus result queue.
// Throughput: one point per cycle while in_ready_o is high; a fiber's last point
// releases up to three results, drained one per cycle while out_ready_i is high
// from an 8-entry result queue. A point's force leaves once two later points (or
// the last point) are in, via the difference, split multiply and update stages.
// in_ready_o drops while eight points are taken but not yet delivered.
// Reset: asynchronous, clears rigidity to 0 and empties window and queue.
`default_nettype none
module fiber_bending_force_stencil_top #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [31:0]     cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire fbs_pkg::coord_t pos_x_i,
  input  wire fbs_pkg::coord_t pos_y_i,
  input  wire fbs_pkg::coord_t pos_z_i,
  input  wire fbs_pkg::coord_t force_in_x_i,
  input  wire fbs_pkg::coord_t force_in_y_i,
  input  wire fbs_pkg::coord_t force_in_z_i,
  input  wire logic            last_point_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output fbs_pkg::coord_t      force_out_x_o,
  output fbs_pkg::coord_t      force_out_y_o,
  output fbs_pkg::coord_t      force_out_z_o,
  output logic                 fiber_end_o
);
  import fbs_pkg::*;

  logic [31:0]     rigidity_q;
  logic [1:0]      held_q, held_d;
  logic [CntW-1:0] owed_q, owed_d;
  logic            acc, pop;
  fbs_ctrl_t       c0, c1_q, c2_q, c3_q;
  fbs_cand_t       cand_x, cand_y, cand_z;
  fbs_result_t     res;

  assign in_ready_o = (owed_q < CntW'(FifoDepth));
  assign acc        = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;

  assign c0 = '{vld: acc, win: (held_q == 2'd2), held: held_q, last: last_point_i};

  always_comb begin
    if (last_point_i) begin
      held_d = 2'd0;
    end else if (held_q == 2'd2) begin
      held_d = 2'd2;
    end else begin
      held_d = held_q + 2'd1;
    end
  end

  // Every point yields exactly one result, so count points owed downstream
  assign owed_d = owed_q + CntW'(acc) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rigidity_q <= '0;
      held_q     <= '0;
      owed_q     <= '0;
      c1_q       <= '0;
      c2_q       <= '0;
      c3_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        rigidity_q <= cfg_wdata_i;
      end
      if (acc) begin
        held_q <= held_d;
      end
      owed_q <= owed_d;
      c1_q   <= c0;
      c2_q   <= c1_q;
      c3_q   <= c2_q;
    end
  end

  fbs_lane u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (c0),
    .pos_i      (pos_x_i),
    .frc_i      (force_in_x_i),
    .rigidity_i (rigidity_q),
    .upd_i      (c3_q),
    .cand_o     (cand_x)
  );

  fbs_lane u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (c0),
    .pos_i      (pos_y_i),
    .frc_i      (force_in_y_i),
    .rigidity_i (rigidity_q),
    .upd_i      (c3_q),
    .cand_o     (cand_y)
  );

  generate
    if (DIMENSIONS == 3) begin : g_lane_z
      fbs_lane u_lane_z (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .acc_i      (c0),
        .pos_i      (pos_z_i),
        .frc_i      (force_in_z_i),
        .rigidity_i (rigidity_q),
        .upd_i      (c3_q),
        .cand_o     (cand_z)
      );
    end else begin : g_no_z
      assign cand_z = '0;
    end
  endgenerate

  fbs_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (c3_q),
    .cand_x_i (cand_x),
    .cand_y_i (cand_y),
    .cand_z_i (cand_z),
    .pop_i    (pop),
    .valid_o  (out_valid_o),
    .result_o (res)
  );

  assign force_out_x_o = res.x;
  assign force_out_y_o = res.y;
  assign force_out_z_o = res.z;
  assign fiber_end_o   = res.fiber_end;

endmodule
`default_nettype wire

[rtl/fbs_checker.sv]
// Port-level checks for the bending-force stencil, bound to the top level.
`default_nettype none
module fbs_checker #(
  parameter int unsigned DIMENSIONS = 3
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        last_point_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] force_out_x_o,
  input wire logic [31:0] force_out_y_o,
  input wire logic [31:0] force_out_z_o,
  input wire logic        fiber_end_o
);
  logic [7:0] pts_q;
  logic [7:0] ends_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Track requests taken but not delivered, and fiber ends owed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q  <= '0;
      ends_q <= '0;
    end else begin
      pts_q  <= pts_q + 8'(in_acc) - 8'(out_acc);
      ends_q <= ends_q + 8'(in_acc && last_point_i) - 8'(out_acc && fiber_end_o);
    end
  end

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pts_q != 8'd0))
    else $error("result offered with no point outstanding");

  a_end_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fiber_end_o) |-> (ends_q != 8'd0))
    else $error("fiber end offered without a last point taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(force_out_x_o) && $stable(force_out_y_o) &&
       $stable(force_out_z_o) && $stable(fiber_end_o)))
    else $error("stalled result changed");

  a_z_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (DIMENSIONS == 2)) |-> (force_out_z_o == 32'd0))
    else $error("z force non-zero in two dimensions");

endmodule

bind fiber_bending_force_stencil_top fbs_checker #(.DIMENSIONS(DIMENSIONS)) u_fbs_checker (.*);
`default_nettype wire

[test/fiber_bending_force_stencil_top_tb.sv]
// Self-checking testbench for the fiber bending-force stencil top level.
module fiber_bending_force_stencil_top_tb;
  import fbs_pkg::*;

  localparam int Dims = 3;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles = 80;
  localparam coord_t CoordMax = 32'sh7FFF_FFFF;
  localparam coord_t CoordMin = 32'sh8000_0000;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t fx;
    coord_t fy;
    coord_t fz;
    logic   last;
  } point_t;

  typedef struct packed {
    point_t      pt;
    logic        typed;
    fbs_result_t want;
  } dir_row_t;

  localparam int DirN = 12;
  localparam fbs_result_t NoWant = '0;
  localparam dir_row_t DirRows [DirN] = '{
    // lone points: forces leave untouched
    '{'{CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, 32'sh1234_5678, 1'b1}, 1'b1,
      '{CoordMin, CoordMax, 32'sh1234_5678, 1'b1}},
    '{'{CoordMin, CoordMax, 32'sh0, CoordMax, CoordMin, -32'sd1, 1'b1}, 1'b1,
      '{CoordMax, CoordMin, -32'sd1, 1'b1}},
    // two-point fiber
    '{'{32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh100, -32'sd256, 32'sh0, 1'b0}, 1'b0, NoWant},
    '{'{32'sh3_0000, 32'sh1_0000, -32'sh3_0000, 32'sh200, 32'sh300, 32'sh400, 1'b1}, 1'b0,
      NoWant},
    // five points zig-zagging between the extremes
    '{'{CoordMax, CoordMin, CoordMax, CoordMax, CoordMin, CoordMax, 1'b0}, 1'b0, NoWant},
    '{'{CoordMin, CoordMax, CoordMin, CoordMin, CoordMax, CoordMin, 1'b0}, 1'b0, NoWant},
    '{'{CoordMax, CoordMin, CoordMax, CoordMax, CoordMin, CoordMax, 1'b0}, 1'b0, NoWant},
    '{'{CoordMin, CoordMax, CoordMin, CoordMin, CoordMax, CoordMin, 1'b0}, 1'b0, NoWant},
    '{'{CoordMax, CoordMin, CoordMax, 32'sh0, 32'sh0, 32'sh0, 1'b1}, 1'b0, NoWant},
    // gently bent three-point fiber
    '{'{32'sh0, 32'sh0, 32'sh0, 32'sh10, -32'sd16, 32'sh0, 1'b0}, 1'b0, NoWant},
    '{'{32'sh8000, 32'sh1_0000, -32'sh1_0000, 32'sh0, 32'sh20, 32'sh7, 1'b0}, 1'b0, NoWant},
    '{'{32'sh2_0000, 32'sh3_0000, 32'sh5, -32'sd5, 32'sh0, 32'sh0, 1'b1}, 1'b0, NoWant}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  coord_t      pos_x_i = '0;
  coord_t      pos_y_i = '0;
  coord_t      pos_z_i = '0;
  coord_t      force_in_x_i = '0;
  coord_t      force_in_y_i = '0;
  coord_t      force_in_z_i = '0;
  logic        last_point_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  coord_t      force_out_x_o;
  coord_t      force_out_y_o;
  coord_t      force_out_z_o;
  logic        fiber_end_o;

  // typed expectation travelling with the current request
  logic        cur_typed = 1'b0;
  fbs_result_t cur_want = '0;

  logic [31:0] rig_q16 = '0;
  coord_t      win_pos [2][3];
  coord_t      win_force [2][3];
  int          held_pts = 0;
  fbs_result_t step_forces [$];
  fbs_result_t due_forces [$];
  fbs_result_t head;

  int n_err = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  fiber_bending_force_stencil_top #(
    .DIMENSIONS(Dims)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .force_in_x_i (force_in_x_i),
    .force_in_y_i (force_in_y_i),
    .force_in_z_i (force_in_z_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .force_out_x_o(force_out_x_o),
    .force_out_y_o(force_out_y_o),
    .force_out_z_o(force_out_z_o),
    .fiber_end_o  (fiber_end_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic coord_t clamp_q16(input longint v);
    if (v > longint'(CoordMax)) return CoordMax;
    if (v < longint'(CoordMin)) return CoordMin;
    return v[31:0];
  endfunction

  function automatic fbs_result_t as_result(input coord_t f [3], input logic fin);
    fbs_result_t r;
    r.x = f[0];
    r.y = f[1];
    r.z = (Dims == 2) ? '0 : f[2];
    r.fiber_end = fin;
    return r;
  endfunction

  // Slide the three-point window over one new point; results go to step_forces.
  function automatic void apply_bending(input point_t p);
    coord_t pos [3];
    coord_t frc [3];
    longint diff;
    longint term;
    longint rh;
    longint rl;
    int d;
    int k;
    step_forces.delete();
    pos = '{p.px, p.py, p.pz};
    frc = '{p.fx, p.fy, p.fz};
    if (Dims == 2) begin
      pos[2] = '0;
      frc[2] = '0;
    end
    rh = longint'({16'b0, rig_q16[31:16]});
    rl = longint'({16'b0, rig_q16[15:0]});
    if (held_pts == 2) begin
      for (d = 0; d < Dims; d++) begin
        diff = longint'(win_pos[0][d]) - 2 * longint'(win_pos[1][d]) + longint'(pos[d]);
        term = diff * rh + ((diff * rl) >>> FracBits);
        win_force[0][d] = clamp_q16(longint'(win_force[0][d]) - term);
        win_force[1][d] = clamp_q16(longint'(win_force[1][d]) + 2 * term);
        frc[d] = clamp_q16(longint'(frc[d]) - term);
      end
      step_forces.push_back(as_result(win_force[0], 1'b0));
      win_force[0] = win_force[1];
      win_pos[0] = win_pos[1];
      held_pts = 1;
    end
    win_force[held_pts] = frc;
    win_pos[held_pts] = pos;
    held_pts++;
    if (p.last) begin
      for (k = 0; k < held_pts; k++)
        step_forces.push_back(as_result(win_force[k], k == held_pts - 1));
      held_pts = 0;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_forces.size() == 0) begin
          $error("result with none outstanding: x %0d y %0d z %0d end %0b",
                 force_out_x_o, force_out_y_o, force_out_z_o, fiber_end_o);
          n_err++;
        end else begin
          head = due_forces.pop_front();
          check_field("force_out_x", head.x, force_out_x_o);
          check_field("force_out_y", head.y, force_out_y_o);
          check_field("force_out_z", head.z, force_out_z_o);
          check_field("fiber_end", {31'b0, head.fiber_end}, {31'b0, fiber_end_o});
        end
      end
      if (in_valid_i && in_ready_o) begin
        apply_bending('{pos_x_i, pos_y_i, pos_z_i, force_in_x_i, force_in_y_i,
                        force_in_z_i, last_point_i});
        if (cur_typed) due_forces.push_back(cur_want);
        else foreach (step_forces[k]) due_forces.push_back(step_forces[k]);
      end
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("fiber_bending_force_stencil_top_tb: errors");
      $finish;
    end
  end

  // hold each request until the block takes it
  task automatic offer_point(input point_t p, input logic typed, input fbs_result_t want);
    pos_x_i <= p.px;
    pos_y_i <= p.py;
    pos_z_i <= p.pz;
    force_in_x_i <= p.fx;
    force_in_y_i <= p.fy;
    force_in_z_i <= p.fz;
    last_point_i <= p.last;
    cur_typed <= typed;
    cur_want <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // drop valid, let every outstanding result arrive, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_forces.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_rigidity(input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    rig_q16 = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic walk_table();
    int i;
    for (i = 0; i < DirN; i++)
      offer_point(DirRows[i].pt, DirRows[i].typed, DirRows[i].want);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(3))
      0: return CoordMax;
      1: return CoordMin;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Whole fibers: mostly smooth curves, some full-range noise, some extremes.
  task automatic run_fibers(input int n_items);
    int sent;
    int len;
    int style;
    int i;
    int d;
    coord_t base [3];
    coord_t slope [3];
    coord_t pos [3];
    coord_t frc [3];
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      style = $urandom_range(9);
      for (d = 0; d < 3; d++) begin
        base[d] = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        slope[d] = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      end
      for (i = 0; i < len; i++) begin
        for (d = 0; d < 3; d++) begin
          if (style < 5) pos[d] = base[d] + i * slope[d] + $urandom_range(0, 8191) - 4096;
          else if (style < 8) pos[d] = $urandom;
          else pos[d] = pick_extreme();
          frc[d] = ($urandom_range(3) == 0) ? $urandom
                                             : $urandom_range(0, 32'hF_FFFF) - 32'h8_0000;
        end
        offer_point('{pos[0], pos[1], pos[2], frc[0], frc[1], frc[2], i == len - 1},
                    1'b0, NoWant);
        sent++;
        sender_gap();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset rigidity, then at full scale
    walk_table();
    settle();
    write_rigidity(32'hFFFF_FFFF);
    walk_table();
    settle();

    write_rigidity(32'h0001_0000);
    run_fibers(100);
    settle();

    send_idle_pct = 77;
    write_rigidity($urandom);
    run_fibers(100);
    settle();

    send_idle_pct = 0;
    stall_pct <= 77;
    write_rigidity(32'hFFFF_FFFF);
    run_fibers(100);
    settle();

    send_idle_pct = 12;
    stall_pct <= 12;
    write_rigidity($urandom_range(0, 32'h0004_0000));
    run_fibers(100);
    settle();

    // back-pressure: hold the receiver off while requests keep coming
    send_idle_pct = 0;
    stall_pct <= 0;
    write_rigidity(32'h0000_8000);
    hold_seq <= hold_seq + 1;
    run_fibers(30);
    settle();

    if (n_err == 0) $display("fiber_bending_force_stencil_top_tb: clean");
    else $display("fiber_bending_force_stencil_top_tb: errors");
    $finish;
  end

endmodule
